[rtl/core/rfid_tag_detection_model_macros.svh]
// Assertion helpers for the tag detection block.
`ifndef RFID_TAG_DETECTION_MODEL_MACROS_SVH
`define RFID_TAG_DETECTION_MODEL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTDM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtdm check failed");

// Next-cycle implication, disabled during reset.
`define RTDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtdm check failed");

`endif

[rtl/core/rtdm_pkg.sv]
package rtdm_pkg;

  localparam int TAG_COUNT_DEF = 1024;
  localparam int IDX_W         = 10;
  localparam int IDX_EXT_W     = 13;
  localparam int POS_W         = 18;
  localparam int ADDR_W        = 5;

  localparam logic [2:0] REG_BWH   = 3'd0;
  localparam logic [2:0] REG_BWV   = 3'd1;
  localparam logic [2:0] REG_R0    = 3'd2;
  localparam logic [2:0] REG_THR   = 3'd3;
  localparam logic [2:0] REG_EDGE  = 3'd4;
  localparam logic [2:0] REG_MARK  = 3'd5;
  localparam logic [2:0] REG_MISS  = 3'd6;

  localparam logic [36:0] RANGE_SQ  = 37'd1677721600;
  localparam logic [14:0] EH_LIMIT  = 15'd12867;
  localparam int HALF_PI_Q16  = 102941;
  localparam int PI_Q16       = 205887;
  localparam int K_Q28        = 163008219;
  localparam int LOG2_3_Q16   = 103872;
  localparam int CORDIC_STEPS = 14;
  localparam int POW_STEPS    = 13;

  typedef struct packed {
    logic [15:0] bwh;
    logic [15:0] bwv;
    logic [17:0] r0;
    logic [16:0] thr;
    logic        edge_only;
    logic        men;
    logic [7:0]  miss_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    bwh: 16'd4096, bwv: 16'd4096, r0: 18'd40960, thr: 17'd32768,
    edge_only: 1'b1, men: 1'b1, miss_limit: 8'd5
  };

  typedef struct packed {
    logic ready;
    logic done;
    logic det;
  } jstat_t;

  function automatic logic [12:0] atan_q13(input logic [3:0] i);
    logic [12:0] r;
    case (i)
      4'd0:    r = 13'd6434;
      4'd1:    r = 13'd3798;
      4'd2:    r = 13'd2007;
      4'd3:    r = 13'd1019;
      4'd4:    r = 13'd511;
      4'd5:    r = 13'd256;
      4'd6:    r = 13'd128;
      4'd7:    r = 13'd64;
      4'd8:    r = 13'd32;
      4'd9:    r = 13'd16;
      4'd10:   r = 13'd8;
      4'd11:   r = 13'd4;
      4'd12:   r = 13'd2;
      4'd13:   r = 13'd1;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/rtdm_judge.sv]
module rtdm_judge
  import rtdm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  cfg_t                    cfg,
  output jstat_t                  stat
);

  typedef enum logic [4:0] {
    J_INIT_LD, J_INIT_RUN, J_IDLE, J_SQX, J_SQY, J_SUM, J_RANGE, J_VEC,
    J_ARG, J_DIV, J_COS, J_CSQ, J_P, J_PCHK, J_SQRT, J_PR, J_V, J_VCHK,
    J_POW, J_DEN, J_FIN
  } jstate_t;

  typedef enum logic [1:0] {OP_ARG, OP_MOD, OP_U, OP_PDF} dop_t;

  jstate_t state_r;
  dop_t    dop_r;
  logic    det_r;
  logic    term_r;

  logic signed [POS_W-1:0] x_r, y_r, z_r;
  logic [35:0] sqx_r, sqy_r;
  logic [36:0] s_r;

  logic signed [29:0] cx_r, cy_r;
  logic signed [15:0] cz_r;
  logic [3:0]  it_r;
  logic [14:0] eh_r, ev_r;

  logic [55:0] dv_r, dq_r;
  logic [54:0] dr_r, dd_r;
  logic [5:0]  dcnt_r;

  logic [16:0] c_r, ph_r, pv_r, p_r;

  logic [61:0] sq_rad_r;
  logic [33:0] sq_rem_r;
  logic [30:0] sq_root_r;
  logic [4:0]  sq_cnt_r;

  logic [30:0] t_r [POW_STEPS];
  logic [3:0]  kk_r;
  logic [19:0] u_r;
  logic [20:0] v_r;
  logic [30:0] mant_r;

  // helpers
  logic signed [35:0] xx, yy;
  logic [17:0] ay, az;
  logic signed [29:0] cxs, cys;
  logic signed [15:0] atan_e;
  logic signed [29:0] cr;
  logic [16:0] c_clamp;
  logic [55:0] d_sh, d_sub;
  logic        d_ge;
  logic [33:0] s_sh, s_trial;
  logic        s_ge;
  logic [3:0]  t_idx;
  logic [30:0] t_rd;
  logic [31:0] t_prev;
  logic [14:0] ang_sel;
  logic [15:0] bw_sel;
  logic [31:0] arg_num;
  logic [17:0] m_raw, m_fold;
  logic [18:0] m_rnd;
  logic [33:0] csq, pprod;
  logic [34:0] prw;
  logic [37:0] vw;
  logic [61:0] mp;
  logic [54:0] den;
  logic [55:0] num_pdf;
  logic [14:0] vec_ang;
  logic        thr_zero;

  assign xx       = x_r * x_r;
  assign yy       = y_r * y_r;
  assign ay       = y_r[POS_W-1] ? (18'd0 - y_r) : y_r;
  assign az       = z_r[POS_W-1] ? (18'd0 - z_r) : z_r;
  assign cxs      = cx_r >>> it_r;
  assign cys      = cy_r >>> it_r;
  assign atan_e   = signed'({3'b000, atan_q13(it_r)});
  assign cr       = (cx_r + 30'sd2048) >>> 12;
  assign c_clamp  = cr[29] ? 17'd0 : ((cr > 30'sd65536) ? 17'd65536 : cr[16:0]);
  assign vec_ang  = cz_r[15] ? 15'd0 : cz_r[14:0];
  assign thr_zero = (cfg.thr == 17'd0);

  // restoring divider step
  assign d_sh  = {dr_r, dv_r[55]};
  assign d_ge  = (d_sh >= {1'b0, dd_r});
  assign d_sub = d_sh - {1'b0, dd_r};

  // restoring square root step, two radicand bits a cycle
  assign s_sh    = {sq_rem_r[31:0], sq_rad_r[61:60]};
  assign s_trial = {1'b0, sq_root_r, 2'b01};
  assign s_ge    = (s_sh >= s_trial);

  assign t_idx  = (state_r == J_POW) ? kk_r : (kk_r - 4'd1);
  assign t_rd   = t_r[t_idx];
  assign t_prev = (kk_r == 4'd0) ? 32'h8000_0000 : {1'b0, t_rd};

  assign ang_sel = term_r ? ev_r : eh_r;
  assign bw_sel  = term_r ? cfg.bwv : cfg.bwh;
  assign arg_num = 32'(ang_sel) * 32'(HALF_PI_Q16) + 32'(bw_sel);

  assign m_raw  = dr_r[17:0];
  assign m_fold = (m_raw > 18'(PI_Q16 / 2)) ? (18'(PI_Q16) - m_raw) : m_raw;
  assign m_rnd  = (19'(m_fold) + 19'd4) >> 3;

  assign csq     = 34'(c_r) * 34'(c_r) + 34'd32768;
  assign pprod   = 34'(ph_r) * 34'(pv_r) + 34'd32768;
  assign prw     = 35'(p_r) * 35'(cfg.r0);
  assign vw      = 38'(u_r) * 38'(LOG2_3_Q16) + 38'd32768;
  assign mp      = 62'(mant_r) * 62'(t_rd) + (62'd1 << 29);
  assign den     = (55'd1 << 30) + (55'(mant_r) << v_r[17:13]);
  assign num_pdf = (56'd1 << 47) + 56'(den >> 1);

  assign stat.ready = (state_r == J_IDLE);
  assign stat.done  = (state_r == J_FIN);
  assign stat.det   = det_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= J_INIT_LD;
      kk_r    <= 4'd0;
      det_r   <= 1'b0;
    end else begin
      unique case (state_r)
        J_INIT_LD: begin
          sq_rad_r  <= {t_prev, 30'b0};
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          sq_cnt_r  <= 5'd31;
          state_r   <= J_INIT_RUN;
        end
        J_INIT_RUN: begin
          if (sq_cnt_r == 5'd0) begin
            t_r[kk_r] <= sq_root_r;
            if (kk_r == 4'(POW_STEPS - 1)) begin
              state_r <= J_IDLE;
            end else begin
              kk_r    <= kk_r + 4'd1;
              state_r <= J_INIT_LD;
            end
          end else begin
            sq_rem_r  <= s_ge ? (s_sh - s_trial) : s_sh;
            sq_root_r <= {sq_root_r[29:0], s_ge};
            sq_rad_r  <= sq_rad_r << 2;
            sq_cnt_r  <= sq_cnt_r - 5'd1;
          end
        end
        J_IDLE: begin
          if (start) begin
            x_r     <= pos_x;
            y_r     <= pos_y;
            z_r     <= pos_z;
            state_r <= J_SQX;
          end
        end
        J_SQX: begin
          sqx_r   <= xx;
          state_r <= J_SQY;
        end
        J_SQY: begin
          sqy_r   <= yy;
          state_r <= J_SUM;
        end
        J_SUM: begin
          s_r     <= 37'(sqx_r) + 37'(sqy_r);
          state_r <= J_RANGE;
        end
        J_RANGE: begin
          if (s_r >= RANGE_SQ || s_r == 37'd0) begin
            det_r   <= 1'b0;
            state_r <= J_FIN;
          end else if (x_r[POS_W-1] || x_r == '0) begin
            det_r   <= thr_zero;
            state_r <= J_FIN;
          end else begin
            cx_r    <= {{4{x_r[POS_W-1]}}, x_r, 8'b0};
            cy_r    <= {4'b0, ay, 8'b0};
            cz_r    <= '0;
            it_r    <= 4'd0;
            term_r  <= 1'b0;
            state_r <= J_VEC;
          end
        end
        J_VEC: begin
          if (it_r == 4'(CORDIC_STEPS) || cy_r == '0) begin
            if (!term_r) begin
              eh_r <= vec_ang;
              if (vec_ang > EH_LIMIT) begin
                det_r   <= thr_zero;
                state_r <= J_FIN;
              end else begin
                cx_r   <= {{4{x_r[POS_W-1]}}, x_r, 8'b0};
                cy_r   <= {4'b0, az, 8'b0};
                cz_r   <= '0;
                it_r   <= 4'd0;
                term_r <= 1'b1;
              end
            end else begin
              ev_r <= vec_ang;
              if (cfg.bwh == 16'd0 || cfg.bwv == 16'd0) begin
                det_r   <= 1'b0;
                state_r <= J_FIN;
              end else begin
                term_r  <= 1'b0;
                state_r <= J_ARG;
              end
            end
          end else begin
            // rotate toward the x axis
            if (!cy_r[29]) begin
              cx_r <= cx_r + cys;
              cy_r <= cy_r - cxs;
              cz_r <= cz_r + atan_e;
            end else begin
              cx_r <= cx_r - cys;
              cy_r <= cy_r + cxs;
              cz_r <= cz_r - atan_e;
            end
            it_r <= it_r + 4'd1;
          end
        end
        J_ARG: begin
          dv_r    <= {arg_num, 24'b0};
          dq_r    <= '0;
          dr_r    <= '0;
          dd_r    <= 55'({bw_sel, 1'b0});
          dcnt_r  <= 6'd32;
          dop_r   <= OP_ARG;
          state_r <= J_DIV;
        end
        J_DIV: begin
          if (dcnt_r == 6'd0) begin
            unique case (dop_r)
              OP_ARG: begin
                dv_r   <= {dq_r[31:0], 24'b0};
                dq_r   <= '0;
                dr_r   <= '0;
                dd_r   <= 55'(PI_Q16);
                dcnt_r <= 6'd32;
                dop_r  <= OP_MOD;
              end
              OP_MOD: begin
                cx_r    <= 30'(K_Q28);
                cy_r    <= '0;
                cz_r    <= 16'(m_rnd);
                it_r    <= 4'd0;
                state_r <= J_COS;
              end
              OP_U: begin
                if (|dq_r[55:20]) begin
                  det_r   <= thr_zero;
                  state_r <= J_FIN;
                end else begin
                  u_r     <= dq_r[19:0];
                  state_r <= J_V;
                end
              end
              OP_PDF: begin
                det_r   <= (dq_r >= 56'(cfg.thr));
                state_r <= J_FIN;
              end
              default: state_r <= J_FIN;
            endcase
          end else begin
            dr_r   <= d_ge ? d_sub[54:0] : d_sh[54:0];
            dq_r   <= {dq_r[54:0], d_ge};
            dv_r   <= dv_r << 1;
            dcnt_r <= dcnt_r - 6'd1;
          end
        end
        J_COS: begin
          if (it_r == 4'(CORDIC_STEPS)) begin
            c_r     <= c_clamp;
            state_r <= J_CSQ;
          end else begin
            if (!cz_r[15]) begin
              cx_r <= cx_r - cys;
              cy_r <= cy_r + cxs;
              cz_r <= cz_r - atan_e;
            end else begin
              cx_r <= cx_r + cys;
              cy_r <= cy_r - cxs;
              cz_r <= cz_r + atan_e;
            end
            it_r <= it_r + 4'd1;
          end
        end
        J_CSQ: begin
          if (!term_r) begin
            ph_r    <= csq[32:16];
            term_r  <= 1'b1;
            state_r <= J_ARG;
          end else begin
            pv_r    <= csq[32:16];
            state_r <= J_P;
          end
        end
        J_P: begin
          p_r     <= pprod[32:16];
          state_r <= J_PCHK;
        end
        J_PCHK: begin
          if (p_r == 17'd0) begin
            det_r   <= 1'b0;
            state_r <= J_FIN;
          end else if (cfg.r0 == 18'd0) begin
            det_r   <= thr_zero;
            state_r <= J_FIN;
          end else begin
            sq_rad_r  <= {31'b0, s_r[30:0]};
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= 5'd31;
            state_r   <= J_SQRT;
          end
        end
        J_SQRT: begin
          if (sq_cnt_r == 5'd0) begin
            state_r <= J_PR;
          end else begin
            sq_rem_r  <= s_ge ? (s_sh - s_trial) : s_sh;
            sq_root_r <= {sq_root_r[29:0], s_ge};
            sq_rad_r  <= sq_rad_r << 2;
            sq_cnt_r  <= sq_cnt_r - 5'd1;
          end
        end
        J_PR: begin
          dv_r    <= {sq_root_r[15:0], 40'b0};
          dq_r    <= '0;
          dr_r    <= '0;
          dd_r    <= 55'(prw);
          dcnt_r  <= 6'd45;
          dop_r   <= OP_U;
          state_r <= J_DIV;
        end
        J_V: begin
          v_r     <= vw[36:16];
          state_r <= J_VCHK;
        end
        J_VCHK: begin
          if (v_r[20:13] >= 8'd24) begin
            det_r   <= thr_zero;
            state_r <= J_FIN;
          end else begin
            mant_r  <= 31'd1 << 30;
            kk_r    <= 4'd0;
            state_r <= J_POW;
          end
        end
        J_POW: begin
          if (kk_r == 4'(POW_STEPS)) begin
            state_r <= J_DEN;
          end else begin
            if (v_r[4'd12 - kk_r]) begin
              mant_r <= mp[60:30];
            end
            kk_r <= kk_r + 4'd1;
          end
        end
        J_DEN: begin
          dv_r    <= num_pdf;
          dq_r    <= '0;
          dr_r    <= '0;
          dd_r    <= den;
          dcnt_r  <= 6'd56;
          dop_r   <= OP_PDF;
          state_r <= J_DIV;
        end
        J_FIN: begin
          state_r <= J_IDLE;
        end
        default: state_r <= J_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/rfid_tag_detection_model.sv]
// Tag detection block: one observation item in, one result item out.
// A present item runs the geometry through one sequencer of serial
// units: two CORDIC vectoring passes of up to 14 steps for the
// horizontal and vertical angles, a 32-step divider twice per beam term
// (argument scaling and reduction by pi), a 14-step CORDIC cosine per
// term, a 31-step square root for the distance, a 45-step division for
// the range ratio, a 13-step power-of-two product and a 56-step division
// for the probability. An item with tag_present low (a miss) skips the
// judge. Tags ruled out early by range or by the horizontal angle finish
// before any division, and a zero pattern is found before the square
// root. Most of a full item's time goes to the shared restoring divider.
// The result sits in an output register, so the next item is taken
// while a result waits. After reset the block clears its per-tag state
// memory, one entry a cycle, and builds its 13-entry root table with the
// square-root unit; no item is taken until both are done, while register
// writes go on.
`include "rfid_tag_detection_model_macros.svh"

module rfid_tag_detection_model
  import rtdm_pkg::*;
#(
  parameter int TAG_COUNT = TAG_COUNT_DEF
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  // observation items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [IDX_W-1:0]        in_tag_index,
  input  logic                    in_tag_present,
  input  logic                    in_scan_start,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  // result items
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_tag_number,
  output logic                    out_detected,
  output logic                    out_report_event,
  output logic                    out_spawn_event,
  output logic                    out_scan_stop,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int TAG_AW = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;

  typedef enum logic [1:0] {T_CLEAR, T_IDLE, T_JUDGE, T_DONE} tstate_t;

  tstate_t state_r;
  logic [TAG_AW-1:0] clr_cnt_r;
  logic [IDX_W-1:0]  idx_r;
  logic              present_r;
  logic              scan_start_r;
  logic              stored_r;
  logic [TAG_AW-1:0] addr_r;
  logic              det_r;
  logic [7:0]        miss_cnt_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_tag_r;
  logic              out_det_r, out_rep_r, out_spawn_r, out_stop_r;
  cfg_t              cfg_r;

  // per-tag state: bit 0 was detected, bit 1 marker shown
  logic [1:0] mem [TAG_COUNT];
  logic [1:0] rd_r;

  logic                 acc;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [TAG_AW-1:0]    in_addr;
  logic                 in_stored;
  logic                 ld;
  logic                 mem_we;
  logic [TAG_AW-1:0]    mem_wa;
  logic [1:0]           mem_wd;
  logic                 prev, shown;
  logic                 rep, spawn;
  logic [7:0]           miss_base, miss_new;
  logic                 stop;
  logic                 cfg_wr;
  logic [2:0]           reg_idx;
  jstat_t               jst;

  assign acc       = in_valid && !in_stall;
  assign idx_ext   = IDX_EXT_W'(in_tag_index);
  assign in_addr   = idx_ext[TAG_AW-1:0];
  assign in_stored = (idx_ext < IDX_EXT_W'(TAG_COUNT));
  assign in_stall  = (state_r != T_IDLE);

  // hand the coordinates of a present tag to the judge at acceptance
  rtdm_judge u_judge (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acc && in_tag_present),
    .pos_x (in_pos_x),
    .pos_y (in_pos_y),
    .pos_z (in_pos_z),
    .cfg   (cfg_r),
    .stat  (jst)
  );

  // result and state update, taken when the output register is free
  assign ld    = (state_r == T_DONE) && (!out_valid_r || !out_stall);
  assign prev  = stored_r && rd_r[0];
  assign shown = stored_r && rd_r[1];
  assign rep   = det_r && (!cfg_r.edge_only || !prev);
  assign spawn = cfg_r.men && det_r && !shown;

  assign miss_base = scan_start_r ? 8'd0 : miss_cnt_r;
  assign miss_new  = present_r ? 8'd0 :
                     ((miss_base == 8'd255) ? miss_base : miss_base + 8'd1);
  assign stop      = !present_r && (miss_new >= cfg_r.miss_limit);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = {det_r && (shown || spawn), det_r};
    if (state_r == T_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = 2'b00;
    end else if (ld && present_r && stored_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (acc) begin
      rd_r <= mem[in_addr];
    end
  end

  // control sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLEAR;
      clr_cnt_r   <= '0;
      miss_cnt_r  <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the taken result unless a new one loads in its place
      if (out_valid_r && !out_stall && !ld) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        T_CLEAR: begin
          // sweep the tag memory and wait for the root table
          if (clr_cnt_r == TAG_AW'(TAG_COUNT - 1)) begin
            if (jst.ready) begin
              state_r <= T_IDLE;
            end
          end else begin
            clr_cnt_r <= clr_cnt_r + TAG_AW'(1);
          end
        end
        T_IDLE: begin
          if (acc) begin
            idx_r        <= in_tag_index;
            present_r    <= in_tag_present;
            scan_start_r <= in_scan_start;
            stored_r     <= in_stored;
            addr_r       <= in_addr;
            det_r        <= 1'b0;
            state_r      <= in_tag_present ? T_JUDGE : T_DONE;
          end
        end
        T_JUDGE: begin
          if (jst.done) begin
            det_r   <= jst.det;
            state_r <= T_DONE;
          end
        end
        T_DONE: begin
          if (ld) begin
            out_valid_r <= 1'b1;
            out_tag_r   <= idx_r;
            out_det_r   <= det_r;
            out_rep_r   <= rep;
            out_spawn_r <= spawn;
            out_stop_r  <= stop;
            miss_cnt_r  <= miss_new;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tag_number   = out_tag_r;
  assign out_detected     = out_det_r;
  assign out_report_event = out_rep_r;
  assign out_spawn_event  = out_spawn_r;
  assign out_scan_stop    = out_stop_r;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BWH:  cfg_r.bwh        <= pwdata[15:0];
        REG_BWV:  cfg_r.bwv        <= pwdata[15:0];
        REG_R0:   cfg_r.r0         <= pwdata[17:0];
        REG_THR:  cfg_r.thr        <= pwdata[16:0];
        REG_EDGE: cfg_r.edge_only  <= pwdata[0];
        REG_MARK: cfg_r.men        <= pwdata[0];
        REG_MISS: cfg_r.miss_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BWH:  prdata = 32'(cfg_r.bwh);
      REG_BWV:  prdata = 32'(cfg_r.bwv);
      REG_R0:   prdata = 32'(cfg_r.r0);
      REG_THR:  prdata = 32'(cfg_r.thr);
      REG_EDGE: prdata = 32'(cfg_r.edge_only);
      REG_MARK: prdata = 32'(cfg_r.men);
      REG_MISS: prdata = 32'(cfg_r.miss_limit);
      default:  prdata = 32'd0;
    endcase
  end

  // the judge is idle whenever an item is taken
  `RTDM_ASSERT_NOW(a_judge_idle_on_accept, acc, jst.ready)
  // one item at a time: hold off input right after an acceptance
  `RTDM_ASSERT_NEXT(a_stall_after_accept, acc, in_stall)
  // no report or spawn without a detection
  `RTDM_ASSERT_NOW(a_events_need_detect, out_valid && !out_detected,
                   !out_report_event && !out_spawn_event)
  // a scan stop comes only from a miss
  `RTDM_ASSERT_NOW(a_stop_on_miss, out_valid && out_scan_stop, !out_detected)

endmodule
